@@ rtl/dfpwm_audio_codec_top_macros.svh @@
// assertion macros shared by the dfpwm codec rtl
// expects clk and arst_n to be visible where a macro is used
`ifndef DFPWM_AUDIO_CODEC_TOP_MACROS_SVH
`define DFPWM_AUDIO_CODEC_TOP_MACROS_SVH
`ifndef SYNTH
`define DFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DFP_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define DFP_ASSERT(lbl, prop, msg)
`define DFP_IMPLY(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/dfpwm_pkg.sv @@
// types and constants of the dfpwm codec
// used by the front, back and top modules
package dfpwm_pkg;

	localparam int QDepth = 2;
	localparam int DecodeBits = 8;

	localparam logic [13:0] StrMax = 14'h3FFF;
	localparam logic [13:0] RiseRateRst = 14'd420;
	localparam logic [13:0] FallRateRst = 14'd3500;

	typedef enum logic [1:0] {
		CfgDirection = 2'd0,
		CfgRiseRate  = 2'd1,
		CfgFallRate  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic        direction;
		logic [13:0] rise_rate;
		logic [13:0] fall_rate;
	} cfg_t;

	// one queued work item
	typedef struct packed {
		logic        dec;
		logic [15:0] pcm;
		logic [7:0]  code;
	} op_t;

endpackage

@@ rtl/dfpwm_front.sv @@
// input side of the dfpwm codec: takes stream transactions, tags them
// with the current direction and holds them in a short queue; uses dfpwm_pkg
module dfpwm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,   // pcm_in[15:0], code_in[23:16]
	input  logic                 direction,
	output logic                 op_valid,
	output dfpwm_pkg::op_t       op,
	input  logic                 op_pop
);

	dfpwm_pkg::op_t op_q [dfpwm_pkg::QDepth];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;
	dfpwm_pkg::op_t op_in;

	assign s_axis_tready = (cnt_q != 2'(dfpwm_pkg::QDepth));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign op_valid      = (cnt_q != 2'd0);
	assign op            = op_q[rd_ptr_q];

	always_comb begin
		op_in.dec  = direction;
		op_in.pcm  = s_axis_tdata[15:0];
		op_in.code = s_axis_tdata[23:16];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (op_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, op_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/dfpwm_back.sv @@
// execution side of the dfpwm codec: charge/strength model, bit packing,
// antijerk and low-pass filter, output register; uses dfpwm_pkg and macros
`include "dfpwm_audio_codec_top_macros.svh"
module dfpwm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dfpwm_pkg::cfg_t      cfg,
	input  logic                 op_valid,
	input  dfpwm_pkg::op_t       op,
	output logic                 op_pop,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [23:0]          m_axis_tdata,   // code_out[7:0], pcm_out[23:8]
	output logic                 m_axis_tlast    // last_of_run
);

	// model state
	logic signed [15:0] charge_q;
	logic [13:0]        strength_q;
	logic               prior_vld_q;
	logic               prior_hi_q;
	logic signed [32:0] jerk_q;
	logic signed [32:0] smooth_q;
	logic [2:0]         bit_cnt_q;
	logic [7:0]         pack_q;
	logic [2:0]         dcnt_q;

	// pipeline
	logic               valid_s1, enc_s1, last_s1;
	logic [7:0]         code_s1;
	logic               valid_s2, enc_s2, last_s2;
	logic [7:0]         code_s2;
	logic signed [16:0] s_s2;

	logic               out_valid_q, out_last_q;
	logic [7:0]         out_code_q;
	logic [15:0]        out_pcm_q;

	logic               en, fire_a, t_hi, same_t, emit_enc;
	logic [7:0]         pack_new;

	// charge path
	logic signed [17:0] tgt, charge_x, diff_c;
	logic signed [32:0] prod_c, rnd_c;
	logic signed [18:0] dlt_c;
	logic signed [19:0] nq;
	logic signed [15:0] charge_d;

	// strength path
	logic signed [15:0] goal, str_x, diff_s;
	logic [13:0]        rate;
	logic signed [30:0] prod_s, rnd_s;
	logic signed [16:0] dlt_s;
	logic signed [17:0] ns;
	logic [13:0]        strength_d;

	// antijerk
	logic signed [16:0] step_j;
	logic signed [50:0] jx, jdec;
	logic signed [32:0] jerk_d;

	// filter
	logic signed [33:0] sum_b;
	logic signed [17:0] tr_b;
	logic signed [16:0] s_b;
	logic signed [34:0] diff_f, nsm;
	logic signed [18:0] tr_f;
	logic [15:0]        pcm_f;

	assign en     = !out_valid_q || m_axis_tready;
	assign fire_a = en && op_valid;
	assign op_pop = fire_a && (!op.dec || (dcnt_q == 3'(dfpwm_pkg::DecodeBits - 1)));

	always_comb begin
		if (op.dec) begin
			t_hi = op.code[dcnt_q];
		end else begin
			t_hi = !(($signed(op.pcm) < charge_q) || (op.pcm == 16'h8000));
		end
		same_t = prior_vld_q && (prior_hi_q == t_hi);
	end

	// charge update: round(strength * (t - charge) / 2^14) with nudge and clamp
	always_comb begin
		tgt      = t_hi ? 18'sd32767 : -18'sd32768;
		charge_x = {{2{charge_q[15]}}, charge_q};
		diff_c   = tgt - charge_x;
		prod_c   = $signed({19'd0, strength_q}) * {{15{diff_c[17]}}, diff_c};
		rnd_c    = prod_c + 33'sd8192;
		dlt_c    = rnd_c[32:14];
		nq       = {{4{charge_q[15]}}, charge_q} + {dlt_c[18], dlt_c};
		if ((dlt_c == 19'sd0) && (charge_x != tgt)) begin
			nq = (tgt > charge_x) ? nq + 20'sd1 : nq - 20'sd1;
		end
		if (nq < -20'sd32768) begin
			charge_d = 16'sh8000;
		end else if (nq > 20'sd32767) begin
			charge_d = 16'sh7FFF;
		end else begin
			charge_d = nq[15:0];
		end
	end

	// strength update toward max on repeat, toward zero on change
	always_comb begin
		goal   = same_t ? {2'b00, dfpwm_pkg::StrMax} : 16'sd0;
		rate   = same_t ? cfg.rise_rate : cfg.fall_rate;
		str_x  = {2'b00, strength_q};
		diff_s = goal - str_x;
		prod_s = $signed({17'd0, rate}) * {{15{diff_s[15]}}, diff_s};
		rnd_s  = prod_s + 31'sd8192;
		dlt_s  = rnd_s[30:14];
		ns     = {{2{str_x[15]}}, str_x} + {dlt_s[16], dlt_s};
		if ((dlt_s == 17'sd0) && (str_x != goal)) begin
			ns = (goal > str_x) ? ns + 18'sd1 : ns - 18'sd1;
		end
		if (ns < 18'sd0) begin
			strength_d = 14'd0;
		end else if (ns > {4'd0, dfpwm_pkg::StrMax}) begin
			strength_d = dfpwm_pkg::StrMax;
		end else begin
			strength_d = ns[13:0];
		end
	end

	// antijerk: step on target change, else decay by 65470/65536 rounded
	always_comb begin
		step_j = {charge_q[15], charge_q} - {charge_d[15], charge_d};
		jx     = {{18{jerk_q[32]}}, jerk_q};
		jdec   = (jx <<< 16) - (jx <<< 6) - (jx <<< 1) + 51'sd32768;
		if (same_t) begin
			jerk_d = jdec[48:16];
		end else begin
			jerk_d = {step_j, 16'd0};
		end
	end

	always_comb begin
		pack_new = pack_q | (8'(t_hi) << bit_cnt_q);
		emit_enc = (bit_cnt_q == 3'd7);
	end

	// stage b: antijerk sum truncated toward zero and saturated
	always_comb begin
		sum_b = {{2{charge_q[15]}}, charge_q, 16'd0} + {jerk_q[32], jerk_q};
		if (sum_b < 34'sd0) begin
			tr_b = 18'((sum_b + 34'sd65535) >>> 16);
		end else begin
			tr_b = 18'(sum_b >>> 16);
		end
		if (tr_b < -18'sd65536) begin
			s_b = 17'sh10000;
		end else if (tr_b > 18'sd65535) begin
			s_b = 17'sh0FFFF;
		end else begin
			s_b = tr_b[16:0];
		end
	end

	// stage c: half-step low-pass and output clamp
	always_comb begin
		diff_f = {{2{s_s2[16]}}, s_s2, 16'd0} - {{2{smooth_q[32]}}, smooth_q};
		nsm    = $signed({{2{smooth_q[32]}}, smooth_q}) + (diff_f >>> 1);
		if (nsm < 35'sd0) begin
			tr_f = 19'((nsm + 35'sd65535) >>> 16);
		end else begin
			tr_f = 19'(nsm >>> 16);
		end
		if (tr_f < -19'sd32768) begin
			pcm_f = 16'h8000;
		end else if (tr_f > 19'sd32767) begin
			pcm_f = 16'h7FFF;
		end else begin
			pcm_f = tr_f[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_q    <= 16'sd0;
			strength_q  <= 14'd0;
			prior_vld_q <= 1'b0;
			prior_hi_q  <= 1'b0;
			jerk_q      <= 33'sd0;
			smooth_q    <= 33'sd0;
			bit_cnt_q   <= 3'd0;
			pack_q      <= 8'd0;
			dcnt_q      <= 3'd0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= fire_a && (op.dec || emit_enc);
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
			if (fire_a) begin
				charge_q    <= charge_d;
				strength_q  <= strength_d;
				prior_vld_q <= 1'b1;
				prior_hi_q  <= t_hi;
				if (op.dec) begin
					jerk_q <= jerk_d;
					dcnt_q <= dcnt_q + 3'd1;
				end else if (emit_enc) begin
					bit_cnt_q <= 3'd0;
					pack_q    <= 8'd0;
				end else begin
					bit_cnt_q <= bit_cnt_q + 3'd1;
					pack_q    <= pack_new;
				end
			end
			if (valid_s2 && !enc_s2) begin
				smooth_q <= nsm[32:0];
			end
		end
	end

	// payload of the pipeline and output register
	always_ff @(posedge clk) begin
		if (en) begin
			enc_s1     <= !op.dec;
			last_s1    <= op.dec && (dcnt_q == 3'(dfpwm_pkg::DecodeBits - 1));
			code_s1    <= op.dec ? 8'd0 : pack_new;
			enc_s2     <= enc_s1;
			last_s2    <= last_s1;
			code_s2    <= code_s1;
			s_s2       <= s_b;
			out_code_q <= code_s2;
			out_pcm_q  <= enc_s2 ? 16'd0 : pcm_f;
			out_last_q <= last_s2;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_pcm_q, out_code_q};
	assign m_axis_tlast  = out_last_q;

	`DFP_IMPLY(a_dcnt_in_decode, dcnt_q != 3'd0, op_valid && op.dec, "bit counter runs without a decode item")
	`DFP_IMPLY(a_pop_at_byte_end, op_pop && op.dec, dcnt_q == 3'd7, "decode item released early")
	`DFP_IMPLY(a_last_only_decode, valid_s2 && last_s2, !enc_s2, "last flag on an encode result")
	`DFP_ASSERT(a_s1_holds, (valid_s1 && !en) |=> (valid_s1 && $stable(code_s1)), "stage one lost on stall")

endmodule

@@ rtl/dfpwm_audio_codec_top.sv @@
// top level of the dfpwm codec: config registers, front queue, back engine
// uses dfpwm_pkg, dfpwm_front and dfpwm_back
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata: pcm_in[15:0], code_in[23:16]
//  m_axis    out  tvalid/tready           tdata: code_out[7:0], pcm_out[23:8]; tlast
//  cfg       in   cfg_we (no wait)        cfg_index selects, cfg_data[13:0]
//
// encode: one sample per cycle through the model update, a byte out every eighth; decode:
// one bit per cycle from the back bit sequencer; both pause while the output stalls; from
// queue head a result passes stage one, stage two and the output register; the two-entry
// queue keeps input open while a result waits; a stalled output freezes the whole back
// pipeline; async reset clears model and valid state; config is read fresh on every item
module dfpwm_audio_codec_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // pcm_in[15:0], code_in[23:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // code_out[7:0], pcm_out[23:8]
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data
);

	dfpwm_pkg::cfg_t cfg_q;
	logic            op_valid;
	logic            op_pop;
	dfpwm_pkg::op_t  op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction <= 1'b0;
			cfg_q.rise_rate <= dfpwm_pkg::RiseRateRst;
			cfg_q.fall_rate <= dfpwm_pkg::FallRateRst;
		end else if (cfg_we) begin
			case (dfpwm_pkg::cfg_idx_t'(cfg_index))
				dfpwm_pkg::CfgDirection: cfg_q.direction <= cfg_data[0];
				dfpwm_pkg::CfgRiseRate:  cfg_q.rise_rate <= cfg_data;
				dfpwm_pkg::CfgFallRate:  cfg_q.fall_rate <= cfg_data;
				default:                 cfg_q <= cfg_q;
			endcase
		end
	end

	dfpwm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.direction     (cfg_q.direction),
		.op_valid      (op_valid),
		.op            (op),
		.op_pop        (op_pop)
	);

	dfpwm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.op_valid      (op_valid),
		.op            (op),
		.op_pop        (op_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

@@ sim/tb.sv @@
// self-checking testbench for dfpwm_audio_codec_top: directed rows, then random phases
// predicts every output with its own model of the codec; needs dfpwm_pkg and the rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int THigh = 32767;
	localparam int TLow = -32768;
	localparam int HalfQ14 = 8192;
	localparam int DecayQ16 = 65470;
	localparam logic [1:0] CfgSpare = 2'd3;   // index past the register list
	localparam int NumRows = 20;

	typedef struct packed {
		logic [7:0]  code;
		logic [15:0] pcm;
		logic        last;
	} codec_out_t;

	typedef struct packed {
		logic        dec;
		logic [15:0] pcm;
		logic [7:0]  code;
		logic        pinned;
		logic [7:0]  want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // pcm_in[15:0], code_in[23:16]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // code_out[7:0], pcm_out[23:8]
	logic        m_axis_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [13:0] cfg_data;

	// codec model state and its copy of the registers
	logic        m_dir;
	logic [13:0] m_rise;
	logic [13:0] m_fall;
	int          chg;
	int          strg;
	int          prior;
	longint      smooth;
	longint      jerk;
	logic [2:0]  nbits;
	logic [7:0]  packed_bits;

	codec_out_t  due_outputs[$];
	codec_out_t  got;
	codec_out_t  want;
	int          mismatches = 0;
	int          idle_in = 0;
	int          idle_out = 0;

	// encode rows carry junk in code_in, decode rows junk in pcm_in
	stim_row_t script [NumRows] = '{
		'{1'b0, 16'h7FFF, 8'h00, 1'b0, 8'h00},
		'{1'b0, 16'h7FFF, 8'hFF, 1'b0, 8'h00},
		'{1'b0, 16'h7FFF, 8'h5A, 1'b0, 8'h00},
		'{1'b0, 16'h7FFF, 8'hA5, 1'b0, 8'h00},
		'{1'b0, 16'h7FFF, 8'h0F, 1'b0, 8'h00},
		'{1'b0, 16'h7FFF, 8'hF0, 1'b0, 8'h00},
		'{1'b0, 16'h7FFF, 8'h33, 1'b0, 8'h00},
		'{1'b0, 16'h7FFF, 8'hCC, 1'b1, 8'hFF},
		// partial byte, then a switch to decode in the middle of it
		'{1'b0, 16'h0000, 8'hA5, 1'b0, 8'h00},
		'{1'b0, 16'hFFFF, 8'h00, 1'b0, 8'h00},
		'{1'b0, 16'h8000, 8'h5A, 1'b0, 8'h00},
		'{1'b0, 16'h0001, 8'hFF, 1'b0, 8'h00},
		'{1'b1, 16'hFFFF, 8'h00, 1'b0, 8'h00},
		'{1'b1, 16'h0000, 8'hFF, 1'b0, 8'h00},
		'{1'b1, 16'h5AA5, 8'h5A, 1'b0, 8'h00},
		'{1'b1, 16'hA55A, 8'hA5, 1'b0, 8'h00},
		// encoding resumes and completes the earlier byte
		'{1'b0, 16'h7FFF, 8'h12, 1'b0, 8'h00},
		'{1'b0, 16'h8001, 8'h34, 1'b0, 8'h00},
		'{1'b0, 16'h1234, 8'h56, 1'b0, 8'h00},
		'{1'b0, 16'hEDCB, 8'h78, 1'b0, 8'h00}
	};

	dfpwm_audio_codec_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic longint trunc16(longint x);
		return (x >= 0) ? (x >>> 16) : -((-x) >>> 16);
	endfunction

	// charge and strength chase target t
	function automatic void follow_target(int t);
		int     goal;
		int     nq;
		int     ns;
		longint rate;
		if (t == prior) begin
			goal = dfpwm_pkg::StrMax;
			rate = longint'(m_rise);
		end else begin
			goal = 0;
			rate = longint'(m_fall);
		end
		nq = chg + int'((longint'(strg) * longint'(t - chg) + HalfQ14) >>> 14);
		if (nq == chg && nq != t)
			nq += (t > nq) ? 1 : -1;
		if (nq < TLow) nq = TLow;
		if (nq > THigh) nq = THigh;
		chg = nq;
		ns = strg + int'((rate * longint'(goal - strg) + HalfQ14) >>> 14);
		if (ns == strg && ns != goal)
			ns += (goal > ns) ? 1 : -1;
		if (ns < 0) ns = 0;
		if (ns > dfpwm_pkg::StrMax) ns = dfpwm_pkg::StrMax;
		strg = ns;
	endfunction

	// one accepted transaction: advance the model, queue what the codec must emit
	function automatic void dfpwm_step(logic [15:0] pcm, logic [7:0] code);
		int     v;
		int     t;
		int     prev_chg;
		longint s;
		longint r;
		if (!m_dir) begin
			v = int'($signed(pcm));
			t = (v < chg || v == TLow) ? TLow : THigh;
			follow_target(t);
			prior = t;
			if (t == THigh)
				packed_bits[nbits] = 1'b1;
			if (nbits == 3'd7) begin
				due_outputs.push_back('{packed_bits, 16'h0000, 1'b0});
				packed_bits = 8'h00;
			end
			nbits = nbits + 3'd1;
		end else begin
			for (int i = 0; i < 8; i++) begin
				t = code[i] ? THigh : TLow;
				prev_chg = chg;
				follow_target(t);
				if (t != prior)
					jerk = longint'(prev_chg - chg) * 65536;
				else
					jerk = (jerk * DecayQ16 + 32768) >>> 16;
				// antijerk sum truncates toward zero and saturates to the signed Q17.0 range
				s = trunc16(longint'(chg) * 65536 + jerk);
				if (s < -65536) s = -65536;
				if (s > 65535) s = 65535;
				smooth += (s * 65536 - smooth) >>> 1;
				r = trunc16(smooth);
				if (r < TLow) r = TLow;
				if (r > THigh) r = THigh;
				prior = t;
				due_outputs.push_back('{8'h00, r[15:0], i == 7});
			end
		end
	endfunction

	task automatic send_item(logic [15:0] pcm, logic [7:0] code);
		while (idle_in != 0 && $urandom_range(99) < idle_in) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {code, pcm};
		do @(posedge clk); while (!s_axis_tready);
		dfpwm_step(pcm, code);
	endtask

	// wait until every queued output is out and the pipeline has emptied
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (due_outputs.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic put_reg(logic [1:0] idx, logic [13:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic load_config(logic dir, logic [13:0] rise, logic [13:0] fall);
		put_reg(CfgSpare, 14'($urandom));
		// bits above bit 0 are junk the codec must drop
		put_reg(dfpwm_pkg::CfgDirection, {13'($urandom), dir});
		put_reg(dfpwm_pkg::CfgRiseRate, rise);
		put_reg(dfpwm_pkg::CfgFallRate, fall);
		cfg_we <= 1'b0;
		m_dir = dir;
		m_rise = rise;
		m_fall = fall;
	endtask

	// output side: random back-pressure and the scoreboard
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= idle_out);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tlast};
			if (due_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: code %h pcm %0d last %b",
						got.code, $signed(got.pcm), got.last);
			end else begin
				want = due_outputs.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: code %h/%h pcm %0d/%0d last %b/%b (exp/act)",
							want.code, got.code, $signed(want.pcm), $signed(got.pcm),
							want.last, got.last);
				end
			end
		end
	end

	initial begin
		int          n;
		int          close_by;
		logic [15:0] pcm;
		logic [7:0]  code;
		logic [13:0] rise;
		logic [13:0] fall;
		codec_out_t  fix;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		m_dir = 1'b0;
		m_rise = dfpwm_pkg::RiseRateRst;
		m_fall = dfpwm_pkg::FallRateRst;
		chg = 0;
		strg = 0;
		prior = 0;
		smooth = 0;
		jerk = 0;
		nbits = 3'd0;
		packed_bits = 8'h00;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_in = 33;
		idle_out = 47;
		for (int k = 0; k < NumRows; k++) begin
			if (script[k].dec != m_dir) begin
				settle();
				load_config(script[k].dec, m_rise, m_fall);
			end
			send_item(script[k].pcm, script[k].code);
			if (script[k].pinned) begin
				fix = due_outputs.pop_back();
				fix.code = script[k].want;
				due_outputs.push_back(fix);
			end
		end

		for (int p = 0; p < 9; p++) begin
			settle();
			idle_in = (p < 3) ? 33 : (p < 6) ? 47 : 0;
			idle_out = (p < 3) ? 47 : (p < 6) ? 33 : 0;
			case (p)
				0: begin rise = 14'd0; fall = 14'd0; end
				1: begin rise = dfpwm_pkg::StrMax; fall = dfpwm_pkg::StrMax; end
				2: begin rise = 14'd0; fall = dfpwm_pkg::StrMax; end
				3: begin rise = dfpwm_pkg::StrMax; fall = 14'd0; end
				4: begin rise = dfpwm_pkg::RiseRateRst; fall = dfpwm_pkg::FallRateRst; end
				default: begin rise = 14'($urandom); fall = 14'($urandom); end
			endcase
			load_config(p % 2 == 1, rise, fall);
			n = (p % 2 == 1) ? 36 : 64;
			repeat (n) begin
				pcm = 16'($urandom);
				code = 8'($urandom);
				if (!m_dir) begin
					case ($urandom_range(7))
						0: pcm = 16'h7FFF;
						1: pcm = 16'h8000;
						2, 3: begin
							// hover around the charge so both bit values stay busy
							close_by = chg + int'($urandom_range(512)) - 256;
							if (close_by < TLow) close_by = TLow;
							if (close_by > THigh) close_by = THigh;
							pcm = close_by[15:0];
						end
						default: ;
					endcase
				end else begin
					case ($urandom_range(7))
						0: code = 8'h00;
						1: code = 8'hFF;
						2: code = $urandom_range(1) ? 8'h55 : 8'hAA;
						default: ;
					endcase
				end
				send_item(pcm, code);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (due_outputs.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && due_outputs.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb NOT OK");
		$finish;
	end

endmodule
